// File: src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, constants and CRC functions
// Holds the queue entry and configuration structures used between the front
// end, the queue and the byte generator of the packet framer.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam logic       CMD_START   = 1'b0;
  localparam logic       CMD_PAYLOAD = 1'b1;

  localparam logic [9:0] MAX_PLEN    = 10'd1010;
  localparam logic [9:0] INNER_HDR   = 10'd13;

  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] OUTER_MARK  = 8'hCC;
  localparam logic [7:0] CRC8_INIT   = 8'h77;
  localparam logic [7:0] CRC8_POLY   = 8'h8C;
  localparam logic [15:0] CRC16_INIT = 16'h3692;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  // Register indexes of the configuration port, at byte address 4 * index.
  localparam logic [1:0] REG_SOURCE_NODE = 2'd0;
  localparam logic [1:0] REG_OUTER_PORT  = 2'd1;
  localparam logic [1:0] REG_PROTO_VER   = 2'd2;

  // Byte positions within a start request.
  localparam logic [4:0] POS_INNER   = 5'd8;
  localparam logic [4:0] POS_LV_HI   = 5'd10;
  localparam logic [4:0] POS_HDR_END = 5'd18;
  localparam logic [4:0] POS_HDR_CRC = 5'd20;
  // Byte positions within a payload request.
  localparam logic [4:0] POS_PAY_CRC = 5'd2;

  typedef struct packed {
    logic        kind;    // CMD_START or CMD_PAYLOAD
    logic        last;    // request closes the frame with the CRC-16
    logic [7:0]  dest;
    logic [7:0]  ctype;
    logic [7:0]  cset;
    logic [7:0]  cid;
    logic [9:0]  ilen;
    logic [15:0] seq;
    logic [7:0]  pbyte;
  } entry_t;

  typedef struct packed {
    logic [7:0]  source_node;
    logic [15:0] outer_port;
    logic [5:0]  protocol_version;
  } cfg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b_in);
    logic [7:0] c;
    logic [7:0] b;
    logic       m;
    c = c_in;
    b = b_in;
    for (int i = 0; i < 8; i++) begin
      m = c[0] ^ b[0];
      c = c >> 1;
      if (m) c = c ^ CRC8_POLY;
      b = b >> 1;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b_in);
    logic [15:0] c;
    logic [7:0]  b;
    logic        m;
    c = c_in;
    b = b_in;
    for (int i = 0; i < 8; i++) begin
      m = c[0] ^ b[0];
      c = c >> 1;
      if (m) c = c ^ CRC16_POLY;
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

// File: src/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front: input request classifier
// Accepts start and payload requests, tracks the open frame and the sequence
// number, drops stray payload bytes and queues work for the byte generator.
// ----------------------------------------------------------------------------
module pfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [7:0]          in_dest,
  input  logic [7:0]          in_ctype,
  input  logic [7:0]          in_cset,
  input  logic [7:0]          in_cid,
  input  logic [9:0]          in_plen,
  input  logic [7:0]          in_pbyte,
  input  logic                q_full,
  output logic                push,
  output pfc_pkg::entry_t     push_entry
);

  logic [15:0] seq_num, seq_num_next;
  logic [9:0]  remaining, remaining_next;
  logic        in_frame, in_frame_next;
  logic [9:0]  plen_sat;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign plen_sat = (in_plen > pfc_pkg::MAX_PLEN) ? pfc_pkg::MAX_PLEN : in_plen;

  always_comb begin
    seq_num_next   = seq_num;
    remaining_next = remaining;
    in_frame_next  = in_frame;
    push           = 1'b0;

    push_entry.kind  = in_cmd;
    push_entry.last  = 1'b0;
    push_entry.dest  = in_dest;
    push_entry.ctype = in_ctype;
    push_entry.cset  = in_cset;
    push_entry.cid   = in_cid;
    push_entry.ilen  = pfc_pkg::INNER_HDR + plen_sat;
    push_entry.seq   = seq_num;
    push_entry.pbyte = in_pbyte;

    if (accept) begin
      if (in_cmd == pfc_pkg::CMD_START) begin
        // A new start simply replaces any frame still open.
        push            = 1'b1;
        push_entry.last = (plen_sat == 10'd0);
        seq_num_next    = seq_num + 16'd1;
        in_frame_next   = (plen_sat != 10'd0);
        remaining_next  = plen_sat;
      end else if (in_frame) begin
        push            = 1'b1;
        push_entry.last = (remaining == 10'd1);
        remaining_next  = remaining - 10'd1;
        in_frame_next   = (remaining != 10'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_num   <= 16'd1;
      remaining <= 10'd0;
      in_frame  <= 1'b0;
    end else begin
      seq_num   <= seq_num_next;
      remaining <= remaining_next;
      in_frame  <= in_frame_next;
    end
  end

  a_frame_count: assert property (@(posedge clk) disable iff (rst)
    in_frame == (remaining != 10'd0))
    else $error("open frame flag and remaining count disagree");

  a_stray_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == pfc_pkg::CMD_PAYLOAD && !in_frame) |-> !push)
    else $error("stray payload byte was queued");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == pfc_pkg::CMD_START) |=> seq_num == $past(seq_num) + 16'd1)
    else $error("sequence number did not advance on a start request");

endmodule

// File: src/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue: request queue
// Small first-in first-out buffer of classified requests between the front
// end and the byte generator.
// ----------------------------------------------------------------------------
module pfc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfc_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output pfc_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  pfc_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("request queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("request queue count out of range");

endmodule

// File: src/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back: byte generator
// Expands each queued request into packet bytes, one per cycle while the output is not stalled, keeping the
// header CRC-8 and body CRC-16 as the bytes go out, into an output register.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic            clk,
  input  logic            rst,
  input  pfc_pkg::cfg_t   cfg,
  input  logic            q_not_empty,
  input  pfc_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_frame_end
);

  logic [4:0]  idx;
  logic [7:0]  crc8;
  logic [15:0] crc16;
  logic        emit;
  logic        is_start;
  logic        final_byte;
  logic        inner;
  logic [7:0]  byte_sel;

  assign emit     = q_not_empty && (!out_valid || out_ready);
  assign is_start = (head.kind == pfc_pkg::CMD_START);
  assign pop      = emit && final_byte;

  always_comb begin
    if (is_start) begin
      final_byte = head.last ? (idx == pfc_pkg::POS_HDR_CRC) : (idx == pfc_pkg::POS_HDR_END);
    end else begin
      final_byte = head.last ? (idx == pfc_pkg::POS_PAY_CRC) : (idx == 5'd0);
    end
  end

  always_comb begin
    inner    = 1'b0;
    byte_sel = 8'h00;
    if (is_start) begin
      inner = (idx >= pfc_pkg::POS_INNER) && (idx <= pfc_pkg::POS_HDR_END);
      case (idx)
        5'd0:    byte_sel = pfc_pkg::SYNC_BYTE;
        5'd1:    byte_sel = pfc_pkg::OUTER_MARK;
        5'd2:    byte_sel = cfg.outer_port[7:0];
        5'd3:    byte_sel = cfg.outer_port[15:8];
        5'd4:    byte_sel = head.ilen[7:0];
        5'd5:    byte_sel = {6'd0, head.ilen[9:8]};
        5'd8:    byte_sel = pfc_pkg::SYNC_BYTE;
        5'd9:    byte_sel = head.ilen[7:0];
        5'd10:   byte_sel = {cfg.protocol_version, head.ilen[9:8]};
        5'd11:   byte_sel = crc8;
        5'd12:   byte_sel = cfg.source_node;
        5'd13:   byte_sel = head.dest;
        5'd14:   byte_sel = head.seq[7:0];
        5'd15:   byte_sel = head.seq[15:8];
        5'd16:   byte_sel = head.ctype;
        5'd17:   byte_sel = head.cset;
        5'd18:   byte_sel = head.cid;
        5'd19:   byte_sel = crc16[7:0];
        5'd20:   byte_sel = crc16[15:8];
        default: byte_sel = 8'h00;
      endcase
    end else begin
      inner = (idx == 5'd0);
      case (idx)
        5'd0:    byte_sel = head.pbyte;
        5'd1:    byte_sel = crc16[7:0];
        5'd2:    byte_sel = crc16[15:8];
        default: byte_sel = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx       <= final_byte ? 5'd0 : idx + 5'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // CRC state and output payload need no reset: the CRC-16 is seeded on the
  // first byte of every start request, the CRC-8 on the inner sync byte.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= byte_sel;
      out_last      <= final_byte;
      out_frame_end <= final_byte && head.last;
      if (is_start && idx == 5'd0) begin
        crc16 <= pfc_pkg::CRC16_INIT;
      end else if (inner) begin
        crc16 <= pfc_pkg::crc16_byte(crc16, byte_sel);
      end
      if (is_start && idx == pfc_pkg::POS_INNER) begin
        crc8 <= pfc_pkg::crc8_byte(pfc_pkg::CRC8_INIT, byte_sel);
      end else if (is_start && idx > pfc_pkg::POS_INNER && idx <= pfc_pkg::POS_LV_HI) begin
        crc8 <= pfc_pkg::crc8_byte(crc8, byte_sel);
      end
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_end) |-> out_last)
    else $error("frame end flagged on a byte that is not the last of its request");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= pfc_pkg::POS_HDR_CRC)
    else $error("byte position out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(idx)))
    else $error("output byte or position changed during a stall");

endmodule

// File: src/packet_framer_crc8_crc16_core.sv
// ----------------------------------------------------------------------------
// packet_framer_crc8_crc16_core: command packet framer
// Frames start and payload requests into a byte stream with an outer header,
// an inner header protected by a CRC-8, and a trailing body CRC-16.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries requests: tuser is the command (0 start, 1 payload byte),
//   tdata the header fields, payload length and payload byte. m_axis carries
//   one packet byte per transfer; tlast marks the last byte caused by a
//   request and tuser marks the final CRC byte that closes a packet.
//   The APB port holds source node, outer port and protocol version; write it
//   only while no request is in flight.
// Latency and throughput
//   An accepted request is first written into the queue, and its first byte
//   is then written into the output register and presented, provided the
//   output is free. The output register emits one byte per cycle while
//   m_axis_tready is high: a start request yields 19 bytes (21 with a zero
//   payload length), a payload byte one (three when it ends the frame). Requests are
//   taken every cycle while the QUEUE_DEPTH entry request queue has room;
//   stray payload bytes are taken and dropped without using the queue.
// Reset and stalls
//   Reset empties the queue, closes any frame, sets the sequence number to 1
//   and restores the register defaults. When m_axis_tready is low the current
//   byte holds, the queue fills and s_axis_tready then falls.
// ----------------------------------------------------------------------------
module packet_framer_crc8_crc16_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] dest_node, [15:8] cmd_type, [23:16] cmd_set, [31:24] cmd_id,
  // [41:32] payload_len, [49:42] payload_byte, [55:50] zero
  input  logic [55:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  // Packet byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] frame_end
  output logic        m_axis_tuser,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pfc_pkg::cfg_t   cfg;
  pfc_pkg::entry_t push_entry;
  pfc_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_not_empty;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_node      <= 8'd2;
      cfg.outer_port       <= 16'd30000;
      cfg.protocol_version <= 6'd1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        pfc_pkg::REG_SOURCE_NODE: cfg.source_node      <= pwdata[7:0];
        pfc_pkg::REG_OUTER_PORT:  cfg.outer_port       <= pwdata[15:0];
        pfc_pkg::REG_PROTO_VER:   cfg.protocol_version <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pfc_pkg::REG_SOURCE_NODE: prdata = {24'd0, cfg.source_node};
      pfc_pkg::REG_OUTER_PORT:  prdata = {16'd0, cfg.outer_port};
      pfc_pkg::REG_PROTO_VER:   prdata = {26'd0, cfg.protocol_version};
      default:                  prdata = 32'd0;
    endcase
  end

  pfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_dest    (s_axis_tdata[7:0]),
    .in_ctype   (s_axis_tdata[15:8]),
    .in_cset    (s_axis_tdata[23:16]),
    .in_cid     (s_axis_tdata[31:24]),
    .in_plen    (s_axis_tdata[41:32]),
    .in_pbyte   (s_axis_tdata[49:42]),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  pfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_last      (m_axis_tlast),
    .out_frame_end (m_axis_tuser)
  );

endmodule

// File: sim/tb_packet_framer_crc8_crc16_core.sv
// ----------------------------------------------------------------------------
// tb_packet_framer_crc8_crc16_core: self-checking bench for the packet framer
// Drives start and payload requests with random gaps, stalls the byte stream
// at random and checks every packet byte, tlast and tuser against a
// cycle-free model of the framer. A directed table comes first, then random
// frames under several register settings, with a gapless run in between.
// ----------------------------------------------------------------------------
module tb_packet_framer_crc8_crc16_core;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 7;
  localparam int QUIET_LIMIT = 2000;
  localparam int RUN_LIMIT   = 400000;
  localparam int SETTLE_PAD  = 10;
  localparam int END_PAD     = 25;
  localparam int PHASE_ITEMS = 30;
  localparam int B2B_FRAMES  = 3;
  localparam int B2B_PLEN    = 4;
  localparam int N_DIRECTED  = 19;

  localparam logic [3:0] ADDR_SOURCE_NODE   = {pfc_pkg::REG_SOURCE_NODE, 2'b00};
  localparam logic [3:0] ADDR_OUTER_PORT    = {pfc_pkg::REG_OUTER_PORT, 2'b00};
  localparam logic [3:0] ADDR_PROTO_VERSION = {pfc_pkg::REG_PROTO_VER, 2'b00};

  typedef struct packed {
    logic       cmd;
    logic [7:0] dest;
    logic [7:0] ctype;
    logic [7:0] cset;
    logic [7:0] cid;
    logic [9:0] plen;
    logic [7:0] pbyte;
  } req_t;

  typedef struct packed {
    req_t        req;
    logic        typed;   // outer header below is given by hand
    logic [63:0] outer;   // outer header, first byte in the lowest bits
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } pkt_byte_t;

  // Outer headers typed in are for the reset register values (port 30000).
  localparam dir_row_t DIR_ROWS [0:N_DIRECTED-1] = '{
    '{'{pfc_pkg::CMD_START,   8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h00}, 1'b1,
      64'h0000_000D_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'hFF}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023, 8'hFF}, 1'b1,
      64'h0000_03FF_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h00}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'hFF}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'hA5}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'h5A, 8'hA5, 8'h3C, 8'hC3, 10'd2,    8'h00}, 1'b1,
      64'h0000_000F_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h3C}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'hC3}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h81}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'h01, 8'h80, 8'h7F, 8'hFE, 10'd1010, 8'h00}, 1'b1,
      64'h0000_03FF_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h01}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'h10, 8'h20, 8'h40, 8'h08, 10'd1,    8'h00}, 1'b1,
      64'h0000_000E_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h7E}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'hAA, 8'h55, 8'hF0, 8'h0F, 10'd1011, 8'h00}, 1'b1,
      64'h0000_03FF_7530_CC55},
    '{'{pfc_pkg::CMD_START,   8'hC3, 8'h3C, 8'h96, 8'h69, 10'd512,  8'h00}, 1'b1,
      64'h0000_020D_7530_CC55},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h55}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_START,   8'h80, 8'h01, 8'h02, 8'h04, 10'd1,    8'h00}, 1'b0, 64'h0},
    '{'{pfc_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0,    8'h00}, 1'b0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [7:0] dest_node, [15:8] cmd_type, [23:16] cmd_set, [31:24] cmd_id,
  // [41:32] payload_len, [49:42] payload_byte, [55:50] zero
  logic [55:0] s_axis_tdata;
  // [0] cmd
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] out_byte
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  // [0] frame_end
  logic        m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Side information that travels with the request being offered.
  logic        outer_typed;
  logic [63:0] outer_want;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;

  // Model state and configuration.
  pfc_pkg::cfg_t regs;
  logic [15:0] seq_no;
  logic [15:0] body_crc;
  logic [9:0]  bytes_left;
  logic        frame_open;
  int          run_len;
  pkt_byte_t   want_bytes[$];

  int n_req, n_starts, n_strays, n_bytes, n_mismatch;
  int quiet_cycles;
  int run_cycles = 0;

  packet_framer_crc8_crc16_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
    for (int k = 0; k < 8; k++)
      c = (c[0] ^ d[k]) ? ((c >> 1) ^ pfc_pkg::CRC8_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    for (int k = 0; k < 8; k++)
      c = (c[0] ^ d[k]) ? ((c >> 1) ^ pfc_pkg::CRC16_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic int pick_gap(input bit fast);
    if (fast || $urandom_range(0, 2) == 0) return 0;
    return int'($urandom_range(0, 13));
  endfunction

  function automatic req_t rand_req(input logic cmd, input logic [9:0] plen);
    req_t r;
    r.cmd   = cmd;
    r.dest  = 8'($urandom);
    r.ctype = 8'($urandom);
    r.cset  = 8'($urandom);
    r.cid   = 8'($urandom);
    r.plen  = plen;
    r.pbyte = 8'($urandom);
    return r;
  endfunction

  function automatic void emit(input logic [7:0] b, input bit inner, input bit fend);
    if (inner) body_crc = crc16_step(body_crc, b);
    want_bytes.push_back({b, 1'b0, fend});
    run_len++;
  endfunction

  function automatic void close_frame();
    emit(body_crc[7:0], 1'b0, 1'b0);
    emit(body_crc[15:8], 1'b0, 1'b1);
    frame_open = 1'b0;
    bytes_left = '0;
  endfunction

  // Works out the packet bytes that one accepted request produces.
  function automatic void frame_request(input logic cmd, input logic [55:0] d,
                                        input logic typed, input logic [63:0] hand_outer);
    logic [9:0]  plen;
    logic [9:0]  ilen;
    logic [15:0] lenw;
    logic [7:0]  hcrc;
    logic [63:0] outer;
    pkt_byte_t   tail;
    run_len = 0;
    if (cmd == pfc_pkg::CMD_START) begin
      plen  = (d[41:32] > pfc_pkg::MAX_PLEN) ? pfc_pkg::MAX_PLEN : d[41:32];
      ilen  = pfc_pkg::INNER_HDR + plen;
      lenw  = {regs.protocol_version, ilen};
      hcrc  = crc8_step(pfc_pkg::CRC8_INIT, pfc_pkg::SYNC_BYTE);
      hcrc  = crc8_step(crc8_step(hcrc, lenw[7:0]), lenw[15:8]);
      outer = {16'h0000, 6'b0, ilen, regs.outer_port, pfc_pkg::OUTER_MARK,
               pfc_pkg::SYNC_BYTE};
      if (typed) outer = hand_outer;
      for (int k = 0; k < 8; k++) emit(outer[8*k +: 8], 1'b0, 1'b0);
      body_crc = pfc_pkg::CRC16_INIT;
      emit(pfc_pkg::SYNC_BYTE, 1'b1, 1'b0);
      emit(lenw[7:0], 1'b1, 1'b0);
      emit(lenw[15:8], 1'b1, 1'b0);
      emit(hcrc, 1'b1, 1'b0);
      emit(regs.source_node, 1'b1, 1'b0);
      emit(d[7:0], 1'b1, 1'b0);
      emit(seq_no[7:0], 1'b1, 1'b0);
      emit(seq_no[15:8], 1'b1, 1'b0);
      emit(d[15:8], 1'b1, 1'b0);
      emit(d[23:16], 1'b1, 1'b0);
      emit(d[31:24], 1'b1, 1'b0);
      seq_no = seq_no + 16'd1;
      if (plen == 10'd0) begin
        close_frame();
      end else begin
        frame_open = 1'b1;
        bytes_left = plen;
      end
    end else if (frame_open) begin
      emit(d[49:42], 1'b1, 1'b0);
      bytes_left = bytes_left - 10'd1;
      if (bytes_left == 10'd0) close_frame();
    end
    if (run_len > 0) begin
      tail = want_bytes.pop_back();
      tail.last = 1'b1;
      want_bytes.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_mismatch++;
  endtask

  // Model, output checking and register shadow, all on the rising edge.
  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst) begin
      regs        = '{8'd2, 16'd30000, 6'd1};
      seq_no      = 16'd1;
      body_crc    = pfc_pkg::CRC16_INIT;
      bytes_left  = '0;
      frame_open  = 1'b0;
      want_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_bytes++;
        if (want_bytes.size() == 0) begin
          report_mismatch("packet byte with nothing expected", m_axis_tdata, 0);
        end else begin
          want = want_bytes.pop_front();
          if (m_axis_tdata !== want.data)
            report_mismatch("out_byte", m_axis_tdata, want.data);
          if (m_axis_tlast !== want.last)
            report_mismatch("run_last (tlast)", m_axis_tlast, want.last);
          if (m_axis_tuser !== want.fend)
            report_mismatch("frame_end (tuser)", m_axis_tuser, want.fend);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_SOURCE_NODE:   regs.source_node      = pwdata[7:0];
          ADDR_OUTER_PORT:    regs.outer_port       = pwdata[15:0];
          ADDR_PROTO_VERSION: regs.protocol_version = pwdata[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_req++;
        if (s_axis_tuser == pfc_pkg::CMD_START) n_starts++;
        else if (!frame_open) n_strays++;
        frame_request(s_axis_tuser, s_axis_tdata, outer_typed, outer_want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    run_cycles <= run_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
    if (run_cycles == RUN_LIMIT) begin
      $display("[%0t] watchdog: run exceeded %0d cycles", $time, RUN_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Byte stream receiver: a random stall before each byte, with bursts of none.
  initial begin : rx_side
    int stall;
    int burst;
    burst = 0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (burst > 0) begin
        stall = 0;
        burst--;
      end else begin
        stall = pick_gap(rx_fast);
        if ($urandom_range(0, 39) == 0) burst = 30;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // Offers one request after a random gap; returns on the falling edge after
  // it is taken, leaving tvalid high so that a gapless request follows on.
  task automatic send_req(input req_t r, input logic typed, input logic [63:0] outer);
    int gap;
    gap = pick_gap(tx_fast);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {6'b0, r.pbyte, r.plen, r.cid, r.cset, r.ctype, r.dest};
    outer_typed   <= typed;
    outer_want    <= outer;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle(input int pad);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (want_bytes.size() != 0) @(negedge clk);
    repeat (pad) @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] node, input logic [15:0] port,
                            input logic [5:0] version);
    write_reg(ADDR_SOURCE_NODE, {24'h0, node});
    write_reg(ADDR_OUTER_PORT, {16'h0, port});
    write_reg(ADDR_PROTO_VERSION, {26'h0, version});
  endtask

  // Mostly complete frames with random content; the rest are oversized or cut
  // short frames that the next start abandons, stray payload bytes and pauses.
  task automatic random_phase(input int quota);
    int made;
    int kind;
    int plen;
    int sends;
    bit open;
    made = 0;
    open = 1'b0;
    while (made < quota) begin
      kind    = int'($urandom_range(0, 19));
      tx_fast = ($urandom_range(0, 5) == 0);
      if (kind == 19) begin
        wait_idle(0);
      end else if (kind >= 17) begin
        if (!open)
          repeat ($urandom_range(1, 3))
            send_req(rand_req(pfc_pkg::CMD_PAYLOAD, 10'($urandom)), 1'b0, 64'h0);
      end else begin
        if (kind < 12) begin
          plen  = $urandom_range(0, 1) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 12));
          sends = plen;
        end else if (kind == 12) begin
          plen  = int'($urandom_range(13, 30));
          sends = plen;
        end else if (kind < 15) begin
          plen  = int'($urandom_range(900, 1023));
          sends = int'($urandom_range(0, 4));
        end else begin
          plen  = int'($urandom_range(2, 10));
          sends = int'($urandom_range(1, plen - 1));
        end
        send_req(rand_req(pfc_pkg::CMD_START, 10'(plen)), 1'b0, 64'h0);
        repeat (sends) send_req(rand_req(pfc_pkg::CMD_PAYLOAD, 10'($urandom)), 1'b0, 64'h0);
        open = (sends < plen);
        made += 1 + sends;
      end
    end
    tx_fast = 1'b0;
    wait_idle(SETTLE_PAD);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pfc_pkg::CMD_START;
    outer_typed   = 1'b0;
    outer_want    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    n_req         = 0;
    n_starts      = 0;
    n_strays      = 0;
    n_bytes       = 0;
    n_mismatch    = 0;
    quiet_cycles  = 0;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_req(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].outer);
    wait_idle(SETTLE_PAD);

    set_config(8'h00, 16'h0000, 6'd0);
    random_phase(PHASE_ITEMS);

    // Gapless frames with no stalls on either side, then two starts of
    // random length, the second abandoning any frame the first left open.
    set_config(8'hFF, 16'hFFFF, 6'd63);
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    for (int f = 0; f < B2B_FRAMES; f++) begin
      send_req(rand_req(pfc_pkg::CMD_START, 10'(B2B_PLEN)), 1'b0, 64'h0);
      repeat (B2B_PLEN)
        send_req(rand_req(pfc_pkg::CMD_PAYLOAD, 10'($urandom)), 1'b0, 64'h0);
    end
    repeat (2)
      send_req(rand_req(pfc_pkg::CMD_START, 10'($urandom_range(0, 1023))), 1'b0, 64'h0);
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    wait_idle(SETTLE_PAD);
    random_phase(PHASE_ITEMS);

    set_config(8'($urandom), 16'($urandom), 6'($urandom));
    random_phase(PHASE_ITEMS);
    set_config(8'($urandom), 16'($urandom), 6'($urandom));
    random_phase(PHASE_ITEMS);

    wait_idle(END_PAD);
    $display("Framed %0d requests (%0d starts, %0d stray payload bytes), %0d bytes checked.",
             n_req, n_starts, n_strays, n_bytes);
    $display("Registers at reset, minimum, maximum and random values, with a gapless run.");
    if (n_mismatch == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
